### rtl/pldm_pkg.sv
// ----------------------------------------------------------------------------
// pldm_pkg: shared types and constants of the path list merge unit
// Command and status codes, FNV-1a constants, case folding, and the
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package pldm_pkg;

  // input commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_REC    = 3'd0;
  localparam logic [2:0] STAT_UNREC  = 3'd1;
  localparam logic [2:0] STAT_DUP    = 3'd2;
  localparam logic [2:0] STAT_NOROOM = 3'd3;
  localparam logic [2:0] STAT_READ   = 3'd4;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [7:0]  SEP_BYTE  = 8'd59;
  localparam logic [12:0] CAP_RESET = 13'd4096;

  // controller -> datapath commands
  typedef struct packed {
    logic       byte_acc;
    logic       rd_acc;
    logic       clear;
    logic       scan_rd;
    logic       scan_next;
    logic       cmp_start;
    logic       cmp_rd;
    logic       cmp_next;
    logic       append;
    logic       fin_done;
    logic       load;
    logic [2:0] load_status;
  } pldm_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_sep;
    logic len_zero;
    logic k_end;
    logic kmatch;
    logic i_end;
    logic bytes_eq;
    logic fits;
    logic table_full;
    logic out_free;
  } pldm_sts_t;

  // ASCII upper case folds to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
    return r;
  endfunction

endpackage

### rtl/pldm_ifs.sv
// ----------------------------------------------------------------------------
// pldm_ifs: valid/ready channels of the path list merge unit
// Input beat carries command, byte and read address; output beat one result.
// ----------------------------------------------------------------------------
interface pldm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic        part_end;
  logic [11:0] read_address;

  modport source (output valid, cmd, data_byte, part_end, read_address, input ready);
  modport sink   (input valid, cmd, data_byte, part_end, read_address, output ready);
endinterface

interface pldm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] entry_start;
  logic [11:0] entry_length;
  logic [11:0] total_length;
  logic [7:0]  read_byte;

  modport source (output valid, status, entry_start, entry_length, total_length,
                  read_byte, input ready);
  modport sink   (input valid, status, entry_start, entry_length, total_length,
                  read_byte, output ready);
endinterface

### rtl/path_list_dedup_merge_unit.sv
// ----------------------------------------------------------------------------
// path_list_dedup_merge_unit: case-insensitive deduplicating path list merge
// Merges ';'-separated path entries into one text, dropping repeats.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per beat: clear, data byte or read byte.
//   out_ch returns at most one result per beat: appended (recorded or not),
//   duplicate, no room, or read data. cfg_we/cfg_wdata set the capacity.
// Sequencing:
//   A data byte that ends no entry leaves the sequencer idle. An entry end
//   goes to FIN, walks the kept table (SCAN_REQ, SCAN_CHK per kept entry)
//   and compares bytes on a hash and length hit (CMP_REQ, CMP_CHK per byte),
//   ending as a duplicate in CMP_REQ or else in DECIDE; an empty entry end
//   returns from FIN to idle. The kept table and text store each have one
//   read port. A read loads its result from S_RD once the output is free.
//   New beats are taken only while the sequencer is idle.
// Reset: merge empty, capacity 4096; the stores need no clearing pass.
// Stall: a pending result sits in the output register; byte beats continue
//   while it waits, and the next result waits until it is taken.
// ----------------------------------------------------------------------------
module path_list_dedup_merge_unit #(
  parameter int MAX_ENTRIES = 512,
  parameter int TEXT_DEPTH  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  pldm_in_if.sink     in_ch,
  pldm_out_if.source  out_ch
);
  import pldm_pkg::*;

  pldm_cmd_t ctl;
  pldm_sts_t sts;

  pldm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_part_end (in_ch.part_end),
    .sts         (sts),
    .ctl         (ctl)
  );

  pldm_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TEXT_DEPTH  (TEXT_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_data_byte     (in_ch.data_byte),
    .in_read_address  (in_ch.read_address),
    .ctl              (ctl),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_entry_start  (out_ch.entry_start),
    .out_entry_length (out_ch.entry_length),
    .out_total_length (out_ch.total_length),
    .out_read_byte    (out_ch.read_byte)
  );

endmodule

### rtl/pldm_ctrl.sv
// ----------------------------------------------------------------------------
// pldm_ctrl: sequencer of the path list merge unit
// Takes input beats in IDLE, walks the kept table and byte compare at the
// end of an entry, and decides append, duplicate or no room.
// ----------------------------------------------------------------------------
module pldm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic                  in_part_end,
  input  pldm_pkg::pldm_sts_t   sts,
  output pldm_pkg::pldm_cmd_t   ctl
);
  import pldm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD       = 3'd1;
  localparam logic [2:0] S_FIN      = 3'd2;
  localparam logic [2:0] S_SCAN_REQ = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_CMP_REQ  = 3'd5;
  localparam logic [2:0] S_CMP_CHK  = 3'd6;
  localparam logic [2:0] S_DECIDE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       stopped_r, stopped_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    stopped_nxt = stopped_r;
    ctl         = '0;
    ctl.load_status = STAT_READ;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_cmd)
            CMD_CLEAR: begin
              ctl.clear   = 1'b1;
              stopped_nxt = 1'b0;
            end
            CMD_READ: begin
              ctl.rd_acc = 1'b1;
              state_nxt  = S_RD;
            end
            CMD_DATA: begin
              if (!stopped_r) begin
                if (sts.is_sep) begin
                  state_nxt = S_FIN;
                end else begin
                  ctl.byte_acc = 1'b1;
                  if (in_part_end) state_nxt = S_FIN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (sts.out_free) begin
          ctl.load        = 1'b1;
          ctl.load_status = STAT_READ;
          state_nxt       = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.len_zero) begin
          ctl.fin_done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: begin
        if (sts.k_end) begin
          state_nxt = S_DECIDE;
        end else begin
          ctl.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.kmatch) begin
          ctl.cmp_start = 1'b1;
          state_nxt     = S_CMP_REQ;
        end else begin
          ctl.scan_next = 1'b1;
          state_nxt     = S_SCAN_REQ;
        end
      end
      S_CMP_REQ: begin
        if (sts.i_end) begin
          // every byte equal: duplicate of the kept entry
          if (sts.out_free) begin
            ctl.load        = 1'b1;
            ctl.load_status = STAT_DUP;
            ctl.fin_done    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          ctl.cmp_rd = 1'b1;
          state_nxt  = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (sts.bytes_eq) begin
          ctl.cmp_next = 1'b1;
          state_nxt    = S_CMP_REQ;
        end else begin
          ctl.scan_next = 1'b1;
          state_nxt     = S_SCAN_REQ;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          ctl.load     = 1'b1;
          ctl.fin_done = 1'b1;
          state_nxt    = S_IDLE;
          if (!sts.fits) begin
            ctl.load_status = STAT_NOROOM;
            stopped_nxt     = 1'b1;
          end else begin
            ctl.append      = 1'b1;
            ctl.load_status = sts.table_full ? STAT_UNREC : STAT_REC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      stopped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stopped_r <= stopped_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a merge that stopped takes no new entry work
  a_stop_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r && state_r == S_IDLE |=> state_r != S_FIN)
    else $error("entry finished while stopped");
  // a result is loaded only from a deciding state
  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (state_r == S_RD || state_r == S_CMP_REQ || state_r == S_DECIDE))
    else $error("result loaded from wrong state");
  // append only happens on a fitting entry
  a_append_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> sts.fits && !stopped_nxt)
    else $error("append without room");
`endif

endmodule

### rtl/pldm_dp.sv
// ----------------------------------------------------------------------------
// pldm_dp: datapath of the path list merge unit
// Hash and length of the current entry, entry buffer, merged text store,
// kept table, capacity check and the output register.
// ----------------------------------------------------------------------------
module pldm_dp #(
  parameter int MAX_ENTRIES = 512,
  parameter int TEXT_DEPTH  = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_wdata,
  input  logic [7:0]            in_data_byte,
  input  logic [11:0]           in_read_address,
  input  pldm_pkg::pldm_cmd_t   ctl,
  output pldm_pkg::pldm_sts_t   sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [11:0]           out_entry_start,
  output logic [11:0]           out_entry_length,
  output logic [11:0]           out_total_length,
  output logic [7:0]            out_read_byte
);
  import pldm_pkg::*;

  localparam int AW  = $clog2(TEXT_DEPTH);
  localparam int LW  = AW + 1;
  localparam int KW  = $clog2(MAX_ENTRIES + 1);
  localparam int KIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int XW  = (LW + 2 > 13) ? LW + 2 : 13;
  localparam int RW  = (LW > 12) ? LW : 12;

  // stores
  logic [7:0]    text_mem [TEXT_DEPTH];
  logic [7:0]    ebuf_mem [TEXT_DEPTH];
  logic [63:0]   kh_mem   [MAX_ENTRIES];
  logic [AW-1:0] ks_mem   [MAX_ENTRIES];
  logic [LW-1:0] kl_mem   [MAX_ENTRIES];

  logic [12:0]   cap_r;
  logic [AW-1:0] wl_r;
  logic [63:0]   hash_r;
  logic [LW-1:0] len_r;
  logic [KW-1:0] kc_r, k_r;
  logic [LW-1:0] i_r;
  logic [63:0]   khd_r;
  logic [AW-1:0] ksd_r;
  logic [LW-1:0] kld_r;
  logic [7:0]    tdat_r, edat_r;
  logic          rd_ok_r;

  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [11:0]   start_o_r, len_o_r, total_o_r;
  logic [7:0]    rbyte_r;
  logic [11:0]   start_o_nxt, len_o_nxt, total_o_nxt;
  logic [7:0]    rbyte_nxt;

  logic [63:0]   hx, hash_nxt;
  logic [LW-1:0] start_w;
  logic [LW:0]   pos_w;
  logic [AW-1:0] wl_nxt;
  logic [XW-1:0] cap_x, dep_x, cap_eff, need_x;
  logic          t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [7:0]    t_wdata;
  logic          out_free;

  // FNV-1a step: xor folded byte, multiply by 2^40 + 0x1b3
  always_comb begin
    hx       = hash_r ^ {56'd0, fold(in_data_byte)};
    hash_nxt = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4)
             + (hx << 1) + hx;
  end

  // placement and capacity check
  always_comb begin
    start_w = LW'(wl_r) + LW'(wl_r != '0);
    pos_w   = (LW+1)'(start_w) + (LW+1)'(len_r);
    wl_nxt  = AW'(start_w + len_r);
    cap_x   = XW'(cap_r);
    dep_x   = XW'(TEXT_DEPTH);
    cap_eff = (cap_x > dep_x) ? dep_x : cap_x;
    need_x  = XW'(start_w) + XW'(len_r) + XW'(1);
  end

  // text store write port: entry bytes land in place, separator on append
  always_comb begin
    t_we    = 1'b0;
    t_waddr = pos_w[AW-1:0];
    t_wdata = in_data_byte;
    if (ctl.byte_acc) begin
      t_we = (pos_w < (LW+1)'(TEXT_DEPTH));
    end else if (ctl.append) begin
      t_we    = (wl_r != '0);
      t_waddr = wl_r;
      t_wdata = SEP_BYTE;
    end
    t_raddr = ctl.rd_acc ? AW'(in_read_address) : AW'(LW'(ksd_r) + i_r);
  end

  always_ff @(posedge clk) begin
    if (t_we) text_mem[t_waddr] <= t_wdata;
    if (ctl.rd_acc || ctl.cmp_rd) tdat_r <= text_mem[t_raddr];
  end

  // entry buffer
  always_ff @(posedge clk) begin
    if (ctl.byte_acc && len_r < LW'(TEXT_DEPTH)) ebuf_mem[len_r[AW-1:0]] <= in_data_byte;
    if (ctl.cmp_rd) edat_r <= ebuf_mem[i_r[AW-1:0]];
  end

  // kept table
  always_ff @(posedge clk) begin
    if (ctl.append && kc_r != KW'(MAX_ENTRIES)) begin
      kh_mem[kc_r[KIW-1:0]] <= hash_r;
      ks_mem[kc_r[KIW-1:0]] <= start_w[AW-1:0];
      kl_mem[kc_r[KIW-1:0]] <= len_r;
    end
    if (ctl.scan_rd) begin
      khd_r <= kh_mem[k_r[KIW-1:0]];
      ksd_r <= ks_mem[k_r[KIW-1:0]];
      kld_r <= kl_mem[k_r[KIW-1:0]];
    end
  end

  // merge state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      wl_r   <= '0;
      hash_r <= FNV_BASIS;
      len_r  <= '0;
      kc_r   <= '0;
      k_r    <= '0;
      i_r    <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (ctl.clear) begin
        wl_r   <= '0;
        kc_r   <= '0;
        hash_r <= FNV_BASIS;
        len_r  <= '0;
        k_r    <= '0;
      end
      if (ctl.byte_acc) begin
        hash_r <= hash_nxt;
        if (len_r != LW'(TEXT_DEPTH)) len_r <= len_r + LW'(1);
      end
      if (ctl.append) begin
        wl_r <= wl_nxt;
        if (kc_r != KW'(MAX_ENTRIES)) kc_r <= kc_r + KW'(1);
      end
      if (ctl.scan_next) k_r <= k_r + KW'(1);
      if (ctl.cmp_start) i_r <= '0;
      if (ctl.cmp_next)  i_r <= i_r + LW'(1);
      if (ctl.fin_done) begin
        hash_r <= FNV_BASIS;
        len_r  <= '0;
        k_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_acc) rd_ok_r <= (RW'(in_read_address) < RW'(wl_r));
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields by status
  always_comb begin
    start_o_nxt = 12'(start_w);
    len_o_nxt   = 12'(len_r);
    total_o_nxt = 12'(wl_r);
    rbyte_nxt   = 8'd0;
    case (ctl.load_status)
      STAT_READ: begin
        start_o_nxt = 12'd0;
        len_o_nxt   = 12'd0;
        rbyte_nxt   = rd_ok_r ? tdat_r : 8'd0;
      end
      STAT_DUP:    start_o_nxt = 12'(ksd_r);
      STAT_NOROOM: ;
      default:     total_o_nxt = 12'(wl_nxt);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status_r  <= ctl.load_status;
      rbyte_r   <= rbyte_nxt;
      start_o_r <= start_o_nxt;
      len_o_r   <= len_o_nxt;
      total_o_r <= total_o_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_entry_start  = start_o_r;
  assign out_entry_length = len_o_r;
  assign out_total_length = total_o_r;
  assign out_read_byte    = rbyte_r;

  // status to controller
  always_comb begin
    sts.is_sep     = (in_data_byte == SEP_BYTE);
    sts.len_zero   = (len_r == '0);
    sts.k_end      = (k_r == kc_r);
    sts.kmatch     = (khd_r == hash_r) && (kld_r == len_r);
    sts.i_end      = (i_r == len_r);
    sts.bytes_eq   = (fold(tdat_r) == fold(edat_r));
    sts.fits       = (need_x <= cap_eff);
    sts.table_full = (kc_r == KW'(MAX_ENTRIES));
    sts.out_free   = out_free;
  end

`ifndef ASSERT_OFF
  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> out_free)
    else $error("output overwritten");
  // scan index never passes the kept count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= kc_r)
    else $error("scan index past kept count");
  // written length grows only by an append
  a_wl_append: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.append && !ctl.clear |=> $stable(wl_r))
    else $error("written length moved without append");
`endif

endmodule

### test/pldm_checker.sv
// ----------------------------------------------------------------------------
// pldm_checker: result predictor and scoreboard for the path list merge unit
// Watches the input, result and capacity ports. Each accepted input beat runs
// through a behavioral merge (FNV-1a on folded bytes, kept table, text store)
// and the result it causes is queued. Every accepted result beat is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module pldm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  pldm_in_if          in_ch,
  pldm_out_if         out_ch,
  output int          errors,
  output int          pending
);
  import pldm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          KEEP_DEPTH = 512;
  localparam int          TEXT_SIZE  = 4096;
  localparam logic [63:0] FNV_PRIME  = 64'h100000001b3;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] entry_start;
    logic [11:0] entry_length;
    logic [11:0] total_length;
    logic [7:0]  read_byte;
  } merge_result_t;

  // model of the merge state
  logic [12:0] cap_reg;
  logic [7:0]  text_mem [TEXT_SIZE];
  logic [7:0]  entry_bytes [TEXT_SIZE];
  int          text_len;
  logic [63:0] run_hash;
  int          run_len;
  logic [63:0] keep_hash [KEEP_DEPTH];
  int          keep_start [KEEP_DEPTH];
  int          keep_len [KEEP_DEPTH];
  int          keep_cnt;
  bit          halted;

  merge_result_t result_q[$];

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  function automatic merge_result_t mk(input logic [2:0] st, input int s, input int l,
                                       input logic [7:0] rb);
    merge_result_t r;
    r.status       = st;
    r.entry_start  = s[11:0];
    r.entry_length = l[11:0];
    r.total_length = text_len[11:0];
    r.read_byte    = rb;
    return r;
  endfunction

  // entry end: look up the kept table, then append or stop
  task automatic close_entry();
    int          len;
    logic [63:0] h;
    int          eff_cap;
    int          sep;
    int          pos;
    bit          same;
    len = run_len;
    h = run_hash;
    run_hash = FNV_BASIS;
    run_len = 0;
    if (len == 0) return;
    for (int k = 0; k < keep_cnt; k++) begin
      if (keep_hash[k] != h || keep_len[k] != len) continue;
      same = 1;
      for (int i = 0; i < len; i++) begin
        if (keep_start[k] + i >= TEXT_SIZE ||
            lower_case(text_mem[keep_start[k] + i]) != lower_case(entry_bytes[i])) begin
          same = 0;
          break;
        end
      end
      if (same) begin
        result_q.push_back(mk(STAT_DUP, keep_start[k], len, 8'd0));
        return;
      end
    end
    eff_cap = (cap_reg > TEXT_SIZE) ? TEXT_SIZE : int'(cap_reg);
    sep = (text_len > 0) ? 1 : 0;
    pos = text_len + sep;
    if (pos + len + 1 > eff_cap) begin
      halted = 1;
      result_q.push_back(mk(STAT_NOROOM, pos, len, 8'd0));
      return;
    end
    if (sep) text_mem[text_len] = SEP_BYTE;
    for (int i = 0; i < len; i++) text_mem[pos + i] = entry_bytes[i];
    text_len = pos + len;
    if (keep_cnt < KEEP_DEPTH) begin
      keep_hash[keep_cnt]  = h;
      keep_start[keep_cnt] = pos;
      keep_len[keep_cnt]   = len;
      keep_cnt++;
      result_q.push_back(mk(STAT_REC, pos, len, 8'd0));
    end else begin
      result_q.push_back(mk(STAT_UNREC, pos, len, 8'd0));
    end
  endtask

  task automatic apply_beat(input logic [1:0] cmd, input logic [7:0] b, input logic last,
                            input logic [11:0] addr);
    logic [7:0] rb;
    if (cmd == CMD_CLEAR) begin
      text_len = 0;
      keep_cnt = 0;
      halted = 0;
      run_hash = FNV_BASIS;
      run_len = 0;
    end else if (cmd == CMD_READ) begin
      rb = (int'(addr) < text_len) ? text_mem[addr] : 8'd0;
      result_q.push_back(mk(STAT_READ, 0, 0, rb));
    end else if (cmd == CMD_DATA && !halted) begin
      if (b == SEP_BYTE) begin
        close_entry();
      end else begin
        run_hash = (run_hash ^ {56'd0, lower_case(b)}) * FNV_PRIME;
        if (run_len < TEXT_SIZE) begin
          entry_bytes[run_len] = b;
          run_len++;
        end
        if (last) close_entry();
      end
    end
  endtask

  // sample all ports at the rising edge
  always @(posedge clk) begin
    merge_result_t got, want;
    if (!rst_n) begin
      cap_reg = CAP_RESET;
      text_len = 0;
      keep_cnt = 0;
      halted = 0;
      run_hash = FNV_BASIS;
      run_len = 0;
      errors = 0;
      result_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        apply_beat(in_ch.cmd, in_ch.data_byte, in_ch.part_end, in_ch.read_address);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.entry_start, out_ch.entry_length,
               out_ch.total_length, out_ch.read_byte};
        if (result_q.size() == 0) begin
          $display("%0t: result beat with none expected: actual %p", $time, got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      pending = result_q.size();
    end
  end
endmodule

### test/path_list_dedup_merge_unit_tb.sv
// ----------------------------------------------------------------------------
// path_list_dedup_merge_unit_tb: stimulus and verdict for the merge unit
// Directed beats cover empty entries, separators with part end, reads past
// the text, an unused command and a capacity that fits nothing. Then random
// path lists with mixed case, noise, reads and clears run under several
// capacities, with random stalls on both channels.
// ----------------------------------------------------------------------------
module path_list_dedup_merge_unit_tb;
  import pldm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STALL_LIMIT = 20000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [12:0] cfg_wdata = '0;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          beats_sent = 0;
  bit          no_gaps = 0;

  pldm_in_if  in_ch ();
  pldm_out_if out_ch ();

  path_list_dedup_merge_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  pldm_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) out_ch.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 14);

  // stall watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[path_list_dedup_merge_unit] ERROR");
      $finish;
    end
  end

  // one input beat, with random gaps before it
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic last,
                           input logic [11:0] addr);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.cmd = cmd;
    in_ch.data_byte = b;
    in_ch.part_end = last;
    in_ch.read_address = addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic data_byte(input logic [7:0] b, input logic last);
    send_beat(CMD_DATA, b, last, 12'($urandom));
  endtask

  task automatic read_at(input logic [11:0] addr);
    send_beat(CMD_READ, 8'($urandom), 1'($urandom), addr);
  endtask

  // all results in and the input channel idle before touching the register
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [12:0] v);
    drain();
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // one path entry with random letter case, ended by ';' or by part end
  task automatic send_path(input string s);
    logic [7:0] c;
    int         how;
    how = $urandom_range(3);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= 8'd97 && c <= 8'd122 && $urandom_range(1)) c = c - 8'd32;
      data_byte(c, (how == 0) && (i == s.len() - 1));
    end
    if (how != 0) data_byte(SEP_BYTE, how == 3);
  endtask

  string words[8] = '{"/usr/bin", "/bin", "c:\\windows", "~/.local/bin", "/opt/x",
                      "a", "ab", "/usr/local/bin"};

  // random traffic until about n more beats have gone in
  task automatic random_phase(input int n);
    int stop_at;
    int r;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 3) send_beat(CMD_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
      else if (r < 14) read_at(($urandom_range(1)) ? 12'($urandom) : 12'($urandom_range(63)));
      else if (r < 16) send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom), 12'($urandom));
      else if (r < 24) data_byte(8'($urandom), $urandom_range(3) == 0);
      else send_path(words[$urandom_range(7)]);
    end
  endtask

  initial begin
    int n;
    in_ch.valid = 0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.data_byte = '0;
    in_ch.part_end = 0;
    in_ch.read_address = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes and corner cases at reset capacity
    read_at(12'd0);
    read_at(12'hfff);
    data_byte("A", 1);
    data_byte(SEP_BYTE, 0);
    data_byte(SEP_BYTE, 1);
    data_byte(8'd0, 0);
    data_byte(8'd255, 0);
    data_byte(SEP_BYTE, 1);
    data_byte("a", 0);
    data_byte(SEP_BYTE, 0);
    data_byte(8'd255, 1);
    send_beat(CMD_UNUSED, 8'hff, 1, 12'hfff);
    read_at(12'd0);
    read_at(12'd1);
    read_at(12'd2);
    read_at(12'd3);
    send_beat(CMD_CLEAR, 8'd0, 0, 12'd0);
    read_at(12'd0);

    // capacity 1: nothing fits, merge stops and ignores bytes
    set_capacity(13'd1);
    data_byte("x", 1);
    data_byte("y", 1);
    read_at(12'd0);
    send_beat(CMD_CLEAR, 8'd0, 0, 12'd0);

    // random path lists under several capacities
    set_capacity(13'd4096);
    random_phase(90);
    set_capacity(13'd30);
    send_beat(CMD_CLEAR, 8'd0, 0, 12'd0);
    random_phase(90);
    set_capacity(13'd8191);
    no_gaps = 1;
    random_phase(90);
    no_gaps = 0;
    n = $urandom_range(1, 4096);
    set_capacity(13'(n));
    random_phase(90);

    drain();
    if (errors == 0) $display("[path_list_dedup_merge_unit] OK");
    else $display("[path_list_dedup_merge_unit] ERROR");
    $finish;
  end
endmodule
